// ----- design/swlr_pkg.sv -----
// ----------------------------------------------------------------------------
// Sliding-window linear regression package
// Payload types, controller/datapath command and status, fixed widths.
// ----------------------------------------------------------------------------
package swlr_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int OUT_W       = 48;
  localparam int CFG_W       = 7;
  localparam int CNT_OUT_W   = 7;
  localparam int NUM_PROD    = 6;
  localparam int PROD_IDX_W  = 3;

  localparam logic [CFG_W-1:0] WINLEN_RESET = 7'd16;

  typedef struct packed {
    logic                          command;
    logic signed [SAMPLE_BITS-1:0] sample_time;
    logic signed [SAMPLE_BITS-1:0] sample_value;
  } in_item_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] slope;
    logic signed [OUT_W-1:0] intercept;
    logic                    status;
    logic [CNT_OUT_W-1:0]    points_held;
  } out_item_t;

  typedef struct packed {
    logic                  accept;
    logic                  ev_sel;
    logic                  sq_en;
    logic                  ev_sub;
    logic                  ad_acc;
    logic                  mul_en;
    logic [PROD_IDX_W-1:0] mul_idx;
    logic                  comb_en;
    logic                  div_start;
    logic                  div_step;
    logic                  out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic evict_needed;
    logic den_zero;
  } dp_status_t;

endpackage

// ----- design/swlr_div.sv -----
// ----------------------------------------------------------------------------
// Restoring divider
// Unsigned quotient, one bit per step, dividend shifted in from the top.
// ----------------------------------------------------------------------------
module swlr_div #(
  parameter int DEN_W = 63,
  parameter int QW    = 79
) (
  input  logic             clk_i,
  input  logic             start_i,
  input  logic             step_i,
  input  logic [QW-1:0]    dividend_i,
  input  logic [DEN_W-1:0] divisor_i,
  output logic [QW-1:0]    quotient_o
);

  logic [DEN_W-1:0] rem_q;
  logic [DEN_W-1:0] dvs_q;
  logic [QW-1:0]    quo_q;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   diff;
  logic             ge;

  assign rem_sh = {rem_q, quo_q[QW-1]};
  assign diff   = rem_sh - {1'b0, dvs_q};
  assign ge     = rem_sh >= {1'b0, dvs_q};

  // The dividend register doubles as the quotient register.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dvs_q <= divisor_i;
      quo_q <= dividend_i;
    end else if (step_i) begin
      rem_q <= ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      quo_q <= {quo_q[QW-2:0], ge};
    end
  end

  assign quotient_o = quo_q;

endmodule

// ----- design/swlr_dp.sv -----
// ----------------------------------------------------------------------------
// Sliding-window linear regression datapath
// Point ring, running sums, shared multiplier, two dividers, result register.
// ----------------------------------------------------------------------------
module swlr_dp import swlr_pkg::*; #(
  parameter int WINDOW_DEPTH  = 64,
  parameter int FRACTION_BITS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  dp_cmd_t          cmd_i,
  output dp_status_t       status_o,
  input  in_item_t         in_i,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  output out_item_t        out_o
);

  localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
  localparam int PTR_W = $clog2(WINDOW_DEPTH);
  localparam int SB    = SAMPLE_BITS;
  localparam int ST_W  = SB + CNT_W;
  localparam int SQ_W  = 2 * SB + CNT_W;
  localparam int PRD_W = ST_W + SQ_W;
  localparam int NUM_W = PRD_W + 1;
  localparam int QW    = NUM_W + FRACTION_BITS;
  localparam int CMP_W = (QW > OUT_W) ? QW : OUT_W + 1;

  logic [CFG_W-1:0]         window_len_q;
  logic signed [SB-1:0]     t_in_q, v_in_q;
  logic [2*SB-1:0]          mem [WINDOW_DEPTH];
  logic [2*SB-1:0]          rd_q;
  logic [PTR_W-1:0]         oldest_q;
  logic [CNT_W-1:0]         fill_q;
  logic signed [ST_W-1:0]   st_q, sv_q;
  logic signed [SQ_W-1:0]   stt_q, sty_q;
  logic signed [SB-1:0]     op_t_q, op_v_q;
  logic signed [2*SB-1:0]   sq_q, tv_q;
  logic signed [PRD_W-1:0]  prod_q [NUM_PROD];
  logic signed [NUM_W-1:0]  den_q, ns_q, ni_q;
  logic                     neg_s_q, neg_i_q;

  logic [31:0]              wl;
  logic [CNT_W-1:0]         len_eff;
  logic [PTR_W:0]           slot_sum, slot_w;
  logic [PTR_W-1:0]         slot;
  logic signed [SB-1:0]     src_t, src_v;
  logic signed [ST_W-1:0]   mul_a;
  logic signed [SQ_W-1:0]   mul_b;
  logic [NUM_W-1:0]         den_mag, ns_mag, ni_mag;
  logic [QW-1:0]            q_s, q_i;
  logic                     den_zero;

  function automatic logic signed [OUT_W-1:0] sat_q(input logic [QW-1:0] q, input logic neg);
    logic [CMP_W-1:0] q_ext;
    logic [CMP_W-1:0] lim;
    logic [CMP_W-1:0] q_neg;
    q_ext = CMP_W'(q);
    lim   = CMP_W'(1) << (OUT_W - 1);
    q_neg = -q_ext;
    if (neg) begin
      sat_q = (q_ext > lim) ? {1'b1, {(OUT_W-1){1'b0}}} : q_neg[OUT_W-1:0];
    end else begin
      sat_q = (q_ext > lim - 1'b1) ? {1'b0, {(OUT_W-1){1'b1}}} : q_ext[OUT_W-1:0];
    end
  endfunction

  // Out-of-range window lengths clip to one and to the ring depth.
  always_comb begin
    wl = 32'(window_len_q);
    if (wl == 32'd0) begin
      len_eff = CNT_W'(1);
    end else if (wl > WINDOW_DEPTH) begin
      len_eff = CNT_W'(WINDOW_DEPTH);
    end else begin
      len_eff = CNT_W'(wl);
    end
  end

  assign slot_sum = {1'b0, oldest_q} + (PTR_W+1)'(fill_q);
  assign slot_w   = (slot_sum >= (PTR_W+1)'(WINDOW_DEPTH)) ?
                    slot_sum - (PTR_W+1)'(WINDOW_DEPTH) : slot_sum;
  assign slot     = slot_w[PTR_W-1:0];

  assign src_t = cmd_i.ev_sel ? signed'(rd_q[2*SB-1:SB]) : t_in_q;
  assign src_v = cmd_i.ev_sel ? signed'(rd_q[SB-1:0])    : v_in_q;

  always_comb begin
    case (cmd_i.mul_idx)
      3'd0: begin mul_a = signed'(ST_W'(fill_q)); mul_b = stt_q;             end
      3'd1: begin mul_a = st_q;                   mul_b = SQ_W'(st_q);       end
      3'd2: begin mul_a = signed'(ST_W'(fill_q)); mul_b = sty_q;             end
      3'd3: begin mul_a = st_q;                   mul_b = SQ_W'(sv_q);       end
      3'd4: begin mul_a = sv_q;                   mul_b = stt_q;             end
      3'd5: begin mul_a = st_q;                   mul_b = sty_q;             end
      default: begin mul_a = '0;                  mul_b = '0;                end
    endcase
  end

  assign den_zero = (den_q == '0);
  assign den_mag  = den_q[NUM_W-1] ? NUM_W'(-den_q) : NUM_W'(den_q);
  assign ns_mag   = ns_q[NUM_W-1]  ? NUM_W'(-ns_q)  : NUM_W'(ns_q);
  assign ni_mag   = ni_q[NUM_W-1]  ? NUM_W'(-ni_q)  : NUM_W'(ni_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_len_q <= WINLEN_RESET;
      oldest_q     <= '0;
      fill_q       <= '0;
      st_q         <= '0;
      sv_q         <= '0;
      stt_q        <= '0;
      sty_q        <= '0;
    end else begin
      if (cfg_we_i) begin
        window_len_q <= cfg_data_i;
      end
      if (cmd_i.accept && in_i.command) begin
        oldest_q <= '0;
        fill_q   <= '0;
        st_q     <= '0;
        sv_q     <= '0;
        stt_q    <= '0;
        sty_q    <= '0;
      end else if (cmd_i.ev_sub) begin
        st_q     <= st_q - ST_W'(op_t_q);
        sv_q     <= sv_q - ST_W'(op_v_q);
        stt_q    <= stt_q - SQ_W'(sq_q);
        sty_q    <= sty_q - SQ_W'(tv_q);
        oldest_q <= (oldest_q == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : oldest_q + 1'b1;
        fill_q   <= fill_q - 1'b1;
      end else if (cmd_i.ad_acc) begin
        st_q   <= st_q + ST_W'(op_t_q);
        sv_q   <= sv_q + ST_W'(op_v_q);
        stt_q  <= stt_q + SQ_W'(sq_q);
        sty_q  <= sty_q + SQ_W'(tv_q);
        fill_q <= fill_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ad_acc) begin
      mem[slot] <= {op_t_q, op_v_q};
    end
    rd_q <= mem[oldest_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      t_in_q <= in_i.sample_time;
      v_in_q <= in_i.sample_value;
    end
    if (cmd_i.sq_en) begin
      op_t_q <= src_t;
      op_v_q <= src_v;
      sq_q   <= src_t * src_t;
      tv_q   <= src_t * src_v;
    end
    if (cmd_i.mul_en) begin
      prod_q[cmd_i.mul_idx] <= mul_a * mul_b;
    end
    if (cmd_i.comb_en) begin
      den_q <= NUM_W'(prod_q[0]) - NUM_W'(prod_q[1]);
      ns_q  <= NUM_W'(prod_q[2]) - NUM_W'(prod_q[3]);
      ni_q  <= NUM_W'(prod_q[4]) - NUM_W'(prod_q[5]);
    end
    if (cmd_i.div_start) begin
      neg_s_q <= ns_q[NUM_W-1] ^ den_q[NUM_W-1];
      neg_i_q <= ni_q[NUM_W-1] ^ den_q[NUM_W-1];
    end
    if (cmd_i.out_load) begin
      out_o.slope       <= den_zero ? '0 : sat_q(q_s, neg_s_q);
      out_o.intercept   <= den_zero ? '0 : sat_q(q_i, neg_i_q);
      out_o.status      <= den_zero;
      out_o.points_held <= CNT_OUT_W'(fill_q);
    end
  end

  swlr_div #(.DEN_W(NUM_W), .QW(QW)) u_div_slope (
    .clk_i      (clk_i),
    .start_i    (cmd_i.div_start),
    .step_i     (cmd_i.div_step),
    .dividend_i (QW'(ns_mag) << FRACTION_BITS),
    .divisor_i  (den_mag),
    .quotient_o (q_s)
  );

  swlr_div #(.DEN_W(NUM_W), .QW(QW)) u_div_icpt (
    .clk_i      (clk_i),
    .start_i    (cmd_i.div_start),
    .step_i     (cmd_i.div_step),
    .dividend_i (QW'(ni_mag) << FRACTION_BITS),
    .divisor_i  (den_mag),
    .quotient_o (q_i)
  );

  assign status_o.evict_needed = (fill_q >= len_eff);
  assign status_o.den_zero     = den_zero;

endmodule

// ----- design/swlr_ctrl.sv -----
// ----------------------------------------------------------------------------
// Sliding-window linear regression controller
// Sequences eviction, accumulation, products, division and result handoff.
// ----------------------------------------------------------------------------
module swlr_ctrl import swlr_pkg::*; #(
  parameter int QW = 79
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_command_i,
  output logic       in_stall_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  localparam int DC_W = (QW > 1) ? $clog2(QW) : 1;

  typedef enum logic [10:0] {
    S_IDLE   = 11'b00000000001,
    S_CHECK  = 11'b00000000010,
    S_EV_MUL = 11'b00000000100,
    S_EV_SUB = 11'b00000001000,
    S_AD_MUL = 11'b00000010000,
    S_AD_ACC = 11'b00000100000,
    S_MUL    = 11'b00001000000,
    S_COMB   = 11'b00010000000,
    S_DSTART = 11'b00100000000,
    S_DIV    = 11'b01000000000,
    S_OUT    = 11'b10000000000
  } state_e;

  state_e                state_q, state_d;
  logic [PROD_IDX_W-1:0] mul_cnt_q, mul_cnt_d;
  logic [DC_W-1:0]       div_cnt_q, div_cnt_d;
  logic                  out_valid_q, out_valid_d;

  always_comb begin
    state_d   = state_q;
    mul_cnt_d = mul_cnt_q;
    div_cnt_d = div_cnt_q;
    cmd_o     = '0;
    cmd_o.mul_idx = mul_cnt_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          mul_cnt_d    = '0;
          state_d      = in_command_i ? S_MUL : S_CHECK;
        end
      end
      S_CHECK: begin
        state_d = status_i.evict_needed ? S_EV_MUL : S_AD_MUL;
      end
      S_EV_MUL: begin
        cmd_o.ev_sel = 1'b1;
        cmd_o.sq_en  = 1'b1;
        state_d      = S_EV_SUB;
      end
      S_EV_SUB: begin
        cmd_o.ev_sub = 1'b1;
        state_d      = S_CHECK;
      end
      S_AD_MUL: begin
        cmd_o.sq_en = 1'b1;
        state_d     = S_AD_ACC;
      end
      S_AD_ACC: begin
        cmd_o.ad_acc = 1'b1;
        state_d      = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul_en = 1'b1;
        mul_cnt_d    = mul_cnt_q + 1'b1;
        if (mul_cnt_q == PROD_IDX_W'(NUM_PROD - 1)) begin
          state_d = S_COMB;
        end
      end
      S_COMB: begin
        cmd_o.comb_en = 1'b1;
        state_d       = S_DSTART;
      end
      S_DSTART: begin
        cmd_o.div_start = 1'b1;
        div_cnt_d       = '0;
        state_d         = status_i.den_zero ? S_OUT : S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        div_cnt_d      = div_cnt_q + 1'b1;
        if (div_cnt_q == DC_W'(QW - 1)) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        // The previous result must have left the output register first.
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mul_cnt_q   <= '0;
      div_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mul_cnt_q   <= mul_cnt_d;
      div_cnt_q   <= div_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ----- design/sliding_window_linear_regression.sv -----
// An add transaction evicts surplus points, accumulates and forms the products; two
// bit-serial dividers then give Q = 3*16 + 2*clog2(WINDOW_DEPTH+1) + 1 + FRACTION_BITS
// quotient bits (79 at the defaults); a zero denominator skips the dividers.
// A clear starts at the products. One transaction is in work at a time;
// the next is accepted once the result is in the output register, even while stalled.
// Reset is asynchronous: empty window, zero sums, window length 16, no valid output.
// ----------------------------------------------------------------------------
// Sliding-window linear regression
// Least-squares line fit over the most recent points, slope and intercept in
// signed fixed point.
// ----------------------------------------------------------------------------
module sliding_window_linear_regression import swlr_pkg::*; #(
  parameter int WINDOW_DEPTH  = 64,
  parameter int FRACTION_BITS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  in_item_t         in_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output out_item_t        out_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [CFG_W-1:0] cfg_data_i
);

  localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
  localparam int NUM_W = 2 * SAMPLE_BITS + 2 * CNT_W + SAMPLE_BITS + 1;
  localparam int QW    = NUM_W + FRACTION_BITS;

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_ready_o = 1'b1;

  swlr_ctrl #(.QW(QW)) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_command_i (in_i.command),
    .in_stall_o   (in_stall_o),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_i     (status),
    .cmd_o        (cmd)
  );

  swlr_dp #(
    .WINDOW_DEPTH  (WINDOW_DEPTH),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .in_i       (in_i),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .out_o      (out_o)
  );

endmodule

// ----- design/swlr_checker.sv -----
// ----------------------------------------------------------------------------
// Sliding-window linear regression checker
// Port-level properties of the fit block, bound to the top level.
// ----------------------------------------------------------------------------
module swlr_checker import swlr_pkg::*; #(
  parameter int WINDOW_DEPTH = 64
) (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_stall_o,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input out_item_t        out_o
);

  // A transaction in work blocks the next one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input accepted while a transaction is in work");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("stalled result dropped");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.status |-> out_o.slope == '0 && out_o.intercept == '0)
    else $error("degenerate fit with nonzero coefficients");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> 32'(out_o.points_held) <= WINDOW_DEPTH)
    else $error("more points held than the window holds");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.points_held < 7'd2 |-> out_o.status)
    else $error("fit reported valid with fewer than two points");

endmodule

bind sliding_window_linear_regression swlr_checker #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_chk (.*);

// ----- sim/sliding_window_linear_regression_test.sv -----
// ----------------------------------------------------------------------------
// Sliding-window linear regression testbench
// Drives points and clears through the valid/stall input channel, predicts
// every fit with exact wide arithmetic and compares it field by field.
// ----------------------------------------------------------------------------
module sliding_window_linear_regression_test import swlr_pkg::*;;

  localparam int DEPTH     = 64;
  localparam int FRAC      = 16;
  localparam int LIMIT     = 2000000;
  localparam int DRAIN     = 400;
  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;
  localparam logic FIT_OK    = 1'b0;
  localparam logic FIT_NONE  = 1'b1;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid_i = 1'b0;
  logic             in_stall_o;
  in_item_t         in_i = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  out_item_t        out_o;
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic [CFG_W-1:0] cfg_data_i = '0;

  sliding_window_linear_regression dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_i,
    .out_valid_o, .out_stall_i, .out_o, .cfg_valid_i, .cfg_ready_o, .cfg_data_i
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Predictor state.
  logic signed [31:0] win_time [DEPTH];
  logic signed [31:0] win_value [DEPTH];
  int unsigned        head;
  int unsigned        count;
  logic signed [63:0] s_t, s_tt, s_tv, s_v;
  logic [6:0]         win_len;

  out_item_t fit_queue [$];
  int        errors = 0;
  int        cycles = 0;
  int        send_gap = 0;
  int        recv_stall = 0;

  task automatic report(input string what, input logic [47:0] got, input logic [47:0] want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    errors++;
  endtask

  function automatic logic [47:0] fixed_quotient(input logic signed [127:0] num,
                                                 input logic signed [127:0] den);
    logic signed [127:0] q;
    q = (num <<< FRAC) / den;
    if (q > 128'sh7FFF_FFFF_FFFF) return 48'h7FFF_FFFF_FFFF;
    if (q < -128'sh8000_0000_0000) return 48'h8000_0000_0000;
    return q[47:0];
  endfunction

  function automatic out_item_t predict_fit(input in_item_t it);
    out_item_t r;
    int unsigned len, slot;
    logic signed [63:0] t, v;
    logic signed [127:0] n, den;
    r = '0;
    if (it.command == CMD_CLEAR) begin
      head = 0; count = 0; s_t = 0; s_tt = 0; s_tv = 0; s_v = 0;
      r.status = FIT_NONE;
      return r;
    end
    len = win_len;
    if (len == 0) len = 1;
    if (len > DEPTH) len = DEPTH;
    while (count >= len) begin
      s_t -= win_time[head]; s_tt -= win_time[head] * win_time[head];
      s_tv -= win_time[head] * win_value[head]; s_v -= win_value[head];
      head = (head + 1) % DEPTH;
      count--;
    end
    t = it.sample_time;
    v = it.sample_value;
    slot = (head + count) % DEPTH;
    win_time[slot] = t;
    win_value[slot] = v;
    count++;
    s_t += t; s_tt += t * t; s_tv += t * v; s_v += v;
    n = count;
    den = n * 128'(s_tt) - 128'(s_t) * 128'(s_t);
    r.points_held = count[6:0];
    if (den == 0) begin
      r.status = FIT_NONE;
      return r;
    end
    r.slope = fixed_quotient(n * 128'(s_tv) - 128'(s_t) * 128'(s_v), den);
    r.intercept = fixed_quotient(128'(s_v) * 128'(s_tt) - 128'(s_t) * 128'(s_tv), den);
    r.status = FIT_OK;
    return r;
  endfunction

  // Valid is dropped only while the sender idles or the test waits for the
  // block to drain, so back-to-back sends assign it once per edge.
  task automatic send_item(input logic cmd, input logic [15:0] t, input logic [15:0] v);
    in_item_t it;
    it.command = cmd; it.sample_time = t; it.sample_value = v;
    while ($urandom_range(99) < send_gap) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_i <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    fit_queue.push_back(predict_fit(it));
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (fit_queue.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
  endtask

  task automatic write_window_len(input logic [6:0] len);
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= len;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    win_len = len;
  endtask

  // Result checker and receiver stall generator.
  always @(posedge clk_i) begin
    out_item_t want;
    cycles++;
    if (cycles > LIMIT) begin
      $display("FAILURE");
      $finish;
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (fit_queue.size() == 0) begin
        report("unexpected result", 48'd0, 48'd0);
      end else begin
        want = fit_queue.pop_front();
        if (out_o.slope !== want.slope) report("slope", out_o.slope, want.slope);
        if (out_o.intercept !== want.intercept)
          report("intercept", out_o.intercept, want.intercept);
        if (out_o.status !== want.status) report("status", out_o.status, want.status);
        if (out_o.points_held !== want.points_held)
          report("points_held", out_o.points_held, want.points_held);
      end
    end
    out_stall_i <= ($urandom_range(99) < recv_stall);
  end

  task automatic test_directed();
    send_item(CMD_ADD, 16'h0005, 16'h0007);
    send_item(CMD_ADD, 16'h0005, 16'h1234);
    send_item(CMD_ADD, 16'h0006, 16'hFFFF);
    send_item(CMD_CLEAR, 16'hFFFF, 16'hFFFF);
    send_item(CMD_ADD, 16'h8000, 16'h8000);
    send_item(CMD_ADD, 16'h7FFF, 16'h7FFF);
    send_item(CMD_ADD, 16'h8000, 16'h7FFF);
    send_item(CMD_ADD, 16'h7FFF, 16'h8000);
    send_item(CMD_CLEAR, 16'h0000, 16'h0000);
    // Adjacent times with extreme values give a steep slope without saturation.
    send_item(CMD_ADD, 16'h0000, 16'h8000);
    send_item(CMD_ADD, 16'h0001, 16'h7FFF);
    send_item(CMD_ADD, 16'h0000, 16'h8000);
    send_item(CMD_ADD, 16'h0001, 16'h7FFF);
    send_item(CMD_CLEAR, 16'h0000, 16'h0000);
  endtask

  task automatic test_window_lengths();
    write_window_len(7'd1);
    repeat (4) send_item(CMD_ADD, 16'($urandom), 16'($urandom));
    write_window_len(7'd0);
    repeat (3) send_item(CMD_ADD, 16'($urandom), 16'($urandom));
    write_window_len(7'd64);
    repeat (70) send_item(CMD_ADD, 16'($urandom), 16'($urandom));
    // Lowering the length evicts several points on the next add.
    write_window_len(7'd3);
    send_item(CMD_ADD, 16'h0010, 16'h0020);
    write_window_len(7'd127);
    repeat (66) send_item(CMD_ADD, 16'($urandom), 16'($urandom));
  endtask

  task automatic test_random(input int items);
    logic [15:0] base, t;
    for (int i = 0; i < items; i++) begin
      if (i % 150 == 0) write_window_len(7'($urandom_range(127)));
      base = 16'($urandom);
      case ($urandom_range(9))
        0: send_item(CMD_CLEAR, 16'($urandom), 16'($urandom));
        1: send_item(CMD_ADD, base & 16'h000F, 16'($urandom));
        2, 3: begin
          t = 16'($urandom_range(3));
          send_item(CMD_ADD, t, 16'($urandom_range(200)) - 16'd100);
        end
        default: send_item(CMD_ADD, 16'($urandom), 16'($urandom));
      endcase
    end
  endtask

  initial begin
    head = 0; count = 0; s_t = 0; s_tt = 0; s_tv = 0; s_v = 0;
    win_len = WINLEN_RESET;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_window_lengths();
    send_gap = 15; recv_stall = 84;
    test_random(350);
    send_gap = 84; recv_stall = 15;
    test_random(350);
    send_gap = 0; recv_stall = 0;
    test_random(350);
    wait_idle();
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
